// File: hw/rtl/ist_pkg.sv
`timescale 1ns / 1ps

package ist_pkg;

	// Store geometry
	localparam int CAPACITY_DEF = 64;
	localparam int VALUE_W      = 32;
	localparam int OP_W         = 2;
	localparam int COUNT_W      = 7;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 16;

	// Operation codes; the unused code behaves as a membership test
	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2
	} op_t;

	// Per-cycle commands broadcast to every cell
	typedef struct packed {
		logic compare;
		logic shift_up;
		logic shift_down;
	} ctrl_t;

endpackage

// File: hw/rtl/ist_cell.sv
`timescale 1ns / 1ps

module ist_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ist_pkg::ctrl_t                    ctrl,
	input  logic                              active,    // slot index below count
	input  logic [ist_pkg::VALUE_W-1:0]       key,       // value being looked up
	input  logic [ist_pkg::VALUE_W-1:0]       up_data,   // lower neighbor, or new value
	input  logic [ist_pkg::VALUE_W-1:0]       dn_data,   // upper neighbor
	input  logic                              dn_hit,    // upper neighbor holds the match
	input  logic [ist_pkg::VALUE_W-1:0]       head_data, // entry of slot zero
	output logic [ist_pkg::VALUE_W-1:0]       entry,
	output logic                              hit
);

	logic [ist_pkg::VALUE_W-1:0] entry_q;
	logic                        hit_s2;

	// Shift up on insert; on remove shift down, and the slot below the
	// removed one takes the head entry so the head is not lost
	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			entry_q <= up_data;
		end else if (ctrl.shift_down) begin
			entry_q <= dn_hit ? head_data : dn_data;
		end
	end

	// Compare against the key in the lookup cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else if (ctrl.compare) begin
			hit_s2 <= active && (entry_q == key);
		end
	end

	assign entry = entry_q;
	assign hit   = hit_s2;

endmodule

// File: hw/rtl/integer_set_table.sv
`timescale 1ns / 1ps

// Set of distinct 32-bit integers held in a row of CAPACITY cells.
// Input stream s_*: s_tuser carries the operation (insert, remove,
// contains), s_tdata the value. Output stream m_*: one beat per input
// beat, with was_present, the entry count after the operation and a flag
// for an insert dropped because the store is full.
// The result is registered after a compare stage, which checks all cells
// at once, and an update stage, which shifts the row and updates the count;
// a stalled m_tready can hold the update stage. No new beat is taken while
// the last is compared; one may be taken as the last leaves the update stage.
// Removal shifts the cells above the matched slot down by one, so the
// order of entries inside the row differs from insertion order.
// Reset empties the set at once; cell contents are never cleared since a
// slot at or above the count is never compared as a hit.
// A stalled m_tready holds the result in the output register; one more
// item may still be taken and looked up, then s_tready drops until the
// result is taken.

module integer_set_table #(
	parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ist_pkg::S_TDATA_W-1:0]   s_tdata,  // [31:0] value
	input  logic [ist_pkg::OP_W-1:0]        s_tuser,  // [1:0] operation
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ist_pkg::M_TDATA_W-1:0]   m_tdata   // [0] was_present, [7:1] entry_count,
	                                                  // [8] rejected_full, [15:9] zero
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]                count_q;
	logic                         cmp_q;
	logic                         upd_q;
	logic [ist_pkg::OP_W-1:0]     op_s1;
	logic [ist_pkg::VALUE_W-1:0]  val_s1;
	logic [ist_pkg::OP_W-1:0]     op_s2;
	logic [ist_pkg::VALUE_W-1:0]  val_s2;
	logic                         m_tvalid_q;
	logic [ist_pkg::M_TDATA_W-1:0] m_data_q;

	logic [CAPACITY-1:0]          hit_vec;
	logic [ist_pkg::VALUE_W-1:0]  entry_vec [CAPACITY];

	ist_pkg::ctrl_t               ctrl;
	logic                         accept;
	logic                         fire;
	logic                         present;
	logic                         full;
	logic                         rejected;
	logic [CW-1:0]                count_next;

	// Handshake and stage control
	assign fire     = upd_q && (!m_tvalid_q || m_tready);
	assign s_tready = !cmp_q && (!upd_q || fire);
	assign accept   = s_tvalid && s_tready;
	assign present  = |hit_vec;
	assign full     = (count_q == CW'(CAPACITY));

	// Decide the row action and the new count
	always_comb begin
		ctrl.compare    = cmp_q;
		ctrl.shift_up   = 1'b0;
		ctrl.shift_down = 1'b0;
		rejected        = 1'b0;
		count_next      = count_q;
		case (ist_pkg::op_t'(op_s2))
			ist_pkg::OP_INSERT: begin
				if (!present) begin
					if (full) begin
						rejected = 1'b1;
					end else begin
						ctrl.shift_up = fire;
						count_next    = count_q + CW'(1);
					end
				end
			end
			ist_pkg::OP_REMOVE: begin
				if (present) begin
					ctrl.shift_down = fire;
					count_next      = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Capture the input beat, pass it to the update stage and register the result
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= s_tuser;
			val_s1 <= s_tdata[ist_pkg::VALUE_W-1:0];
		end
		if (cmp_q) begin
			op_s2  <= op_s1;
			val_s2 <= val_s1;
		end
		if (fire) begin
			m_data_q <= {
				(ist_pkg::M_TDATA_W - 2 - ist_pkg::COUNT_W)'(0),
				rejected,
				ist_pkg::COUNT_W'(count_next),
				present
			};
		end
	end

	// Stage flags, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q      <= 1'b0;
			upd_q      <= 1'b0;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cmp_q <= accept;
			if (cmp_q) begin
				upd_q <= 1'b1;
			end else if (fire) begin
				upd_q <= 1'b0;
			end
			if (fire) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ist_pkg::VALUE_W-1:0] up_d;
		logic [ist_pkg::VALUE_W-1:0] dn_d;
		logic                        dn_h;

		if (i == 0) begin : g_first
			assign up_d = val_s2;
		end else begin : g_mid
			assign up_d = entry_vec[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign dn_d = entry_vec[i];
			assign dn_h = 1'b0;
		end else begin : g_inner
			assign dn_d = entry_vec[i+1];
			assign dn_h = hit_vec[i+1];
		end

		ist_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.active    (count_q > CW'(i)),
			.key       (val_s1),
			.up_data   (up_d),
			.dn_data   (dn_d),
			.dn_hit    (dn_h),
			.head_data (entry_vec[0]),
			.entry     (entry_vec[i]),
			.hit       (hit_vec[i])
		);
	end

endmodule

// File: bench/integer_set_table_test.sv
`timescale 1ns / 1ps

module integer_set_table_test;

	import ist_pkg::*;

	localparam int CAPACITY      = CAPACITY_DEF;
	localparam int RANDOM_ITEMS  = 2000;
	localparam int QUIET_ITEMS   = 300;
	localparam int POOL_SIZE     = 96;
	localparam int STUCK_LIMIT   = 500;
	localparam int DRAIN_CYCLES  = 8;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic               was_present;
		logic [COUNT_W-1:0] entry_count;
		logic               rejected_full;
	} set_result_t;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
		bit                 typed;
		set_result_t        res;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;  // [31:0] value
	logic [OP_W-1:0]      s_tuser = '0;  // [1:0] operation
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;       // [0] was_present, [7:1] entry_count,
	                                     // [8] rejected_full, [15:9] zero

	// Shadow copy of the set and the results still owed by the block
	logic [VALUE_W-1:0] shadow_members [CAPACITY];
	int                 shadow_count = 0;
	set_result_t        expected_results [$];
	stim_row_t          directed_rows [$];
	logic [VALUE_W-1:0] value_pool [POOL_SIZE];
	int                 mismatches = 0;
	bit                 quiet_tail = 1'b0;
	int                 stuck_cycles = 0;

	integer_set_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	// Apply one operation to the shadow set and return what the block should answer
	task automatic apply_set_op(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			output set_result_t res);
		int slot;
		slot = -1;
		for (int i = 0; i < shadow_count; i++) begin
			if (shadow_members[i] == value) begin
				slot = i;
				break;
			end
		end
		res.was_present = (slot >= 0);
		res.rejected_full = 1'b0;
		if (op == OP_INSERT) begin
			if (slot < 0) begin
				if (shadow_count < CAPACITY) begin
					shadow_members[shadow_count] = value;
					shadow_count++;
				end else begin
					res.rejected_full = 1'b1;
				end
			end
		end else if (op == OP_REMOVE && slot >= 0) begin
			// move the last entry into the freed slot
			shadow_members[slot] = shadow_members[shadow_count - 1];
			shadow_count--;
		end
		res.entry_count = COUNT_W'(shadow_count);
	endtask

	task automatic add_row(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			input bit typed, input logic present, input int count, input logic rejected);
		stim_row_t row;
		row.op = op;
		row.value = value;
		row.typed = typed;
		row.res.was_present = present;
		row.res.entry_count = COUNT_W'(count);
		row.res.rejected_full = rejected;
		directed_rows.push_back(row);
	endtask

	// Offer one beat, predict on acceptance, then maybe idle for a burst
	task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			input bit typed, input set_result_t typed_res);
		bit          taken;
		set_result_t predicted;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
		apply_set_op(op, value, predicted);
		expected_results.push_back(typed ? typed_res : predicted);
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// Refill the value pool: wide random patterns or a small signed range
	task automatic refill_pool(input bit wide);
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (wide)
				value_pool[i] = ($urandom << 7) | VALUE_W'(i);
			else
				value_pool[i] = VALUE_W'(i - 48);
		end
	endtask

	task automatic check_result(input logic [M_TDATA_W-1:0] beat);
		set_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("result beat 0x%04h with nothing pending", beat));
		end else begin
			want = expected_results.pop_front();
			if (beat[0] !== want.was_present)
				report_mismatch($sformatf("was_present got %0b want %0b",
					beat[0], want.was_present));
			if (beat[7:1] !== want.entry_count)
				report_mismatch($sformatf("entry_count got %0d want %0d",
					beat[7:1], want.entry_count));
			if (beat[8] !== want.rejected_full)
				report_mismatch($sformatf("rejected_full got %0b want %0b",
					beat[8], want.rejected_full));
		end
	endtask

	// Result side: stall in random bursts, check each beat taken
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(0, 11);
			end else begin
				m_tready <= 1'b1;
			end
			@(negedge clk);
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			@(posedge clk);
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long
	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		set_result_t      no_res;
		logic [OP_W-1:0]  op;
		logic [VALUE_W-1:0] value;
		int               sent;
		int               phase;
		int               insert_pct;
		no_res = '0;

		// Hold reset, then release it
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, duplicates, absent removal, last-entry removal,
		// unused opcode; typed results only where obvious
		add_row(OP_CONTAINS, 32'h0000_0000, 1, 0, 0, 0);
		add_row(OP_REMOVE,   32'h0000_0005, 1, 0, 0, 0);
		add_row(OP_INSERT,   32'h8000_0000, 1, 0, 1, 0);
		add_row(OP_INSERT,   32'h7FFF_FFFF, 1, 0, 2, 0);
		add_row(OP_INSERT,   32'h8000_0000, 1, 1, 2, 0);
		add_row(OP_INSERT,   32'h0000_0000, 0, 0, 0, 0);
		add_row(OP_INSERT,   32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(OP_CONTAINS, 32'h7FFF_FFFF, 0, 0, 0, 0);
		add_row(OP_UNUSED,   32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(OP_UNUSED,   32'h0001_2345, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'h0001_2345, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'h8000_0000, 0, 0, 0, 0);
		add_row(OP_CONTAINS, 32'h8000_0000, 0, 0, 0, 0);
		add_row(OP_CONTAINS, 32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'hFFFF_FFFF, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'h7FFF_FFFF, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'h0000_0000, 0, 0, 0, 0);
		add_row(OP_INSERT,   32'h5555_5555, 0, 0, 0, 0);
		add_row(OP_INSERT,   32'hAAAA_AAAA, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'hAAAA_AAAA, 0, 0, 0, 0);
		add_row(OP_CONTAINS, 32'h5555_5555, 0, 0, 0, 0);
		add_row(OP_REMOVE,   32'h5555_5555, 0, 0, 0, 0);
		foreach (directed_rows[i])
			send_beat(directed_rows[i].op, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].res);

		// Fill past capacity so the full-store rejection shows up
		refill_pool(1'b1);
		sent = 0;
		for (int i = 0; i < CAPACITY + 6; i++) begin
			send_beat(OP_INSERT, value_pool[i], 1'b0, no_res);
			sent++;
		end

		// Hold off until every pending result has come back
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);

		// Random phases with a drifting insert/remove mix over a shared value pool
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase % 4 == 0)
				refill_pool(phase % 8 == 0);
			insert_pct = $urandom_range(15, 85);
			repeat (100) begin
				if ($urandom_range(0, 99) < insert_pct) begin
					op = OP_INSERT;
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: op = OP_REMOVE;
						6, 7, 8:          op = OP_CONTAINS;
						default:          op = OP_UNUSED;
					endcase
				end
				if ($urandom_range(0, 6) == 0)
					value = $urandom;
				else
					value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
				quiet_tail = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
				send_beat(op, value, 1'b0, no_res);
				sent++;
			end
			phase++;
		end
		s_tvalid <= 1'b0;

		// Drain outstanding results, then allow a few more cycles for strays
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: files.f
hw/rtl/ist_pkg.sv
hw/rtl/ist_cell.sv
hw/rtl/integer_set_table.sv
bench/integer_set_table_test.sv
